/* design/scled_pkg.sv */
`timescale 1ns / 1ps

package scled_pkg;

  // Input op codes
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // Characters and reload values
  localparam logic [7:0] FrameMark  = 8'd42;   // '*'
  localparam logic [7:0] DigitBase  = 8'd48;   // '0'
  localparam logic [7:0] ChanFirst  = 8'd49;   // '1'
  localparam logic [7:0] ChanLast   = 8'd51;   // '3'
  localparam logic [7:0] ReloadSlow = 8'd50;
  localparam logic [7:0] ReloadMid  = 8'd100;
  localparam logic [7:0] ReloadFast = 8'd150;

  // Level digit codes, relative to '0'
  localparam logic [7:0] LvlSlow = 8'd1;
  localparam logic [7:0] LvlMid  = 8'd2;
  localparam logic [7:0] LvlFast = 8'd3;
  localparam logic [7:0] LvlHigh = 8'd4;
  localparam logic [7:0] LvlLow  = 8'd5;

  localparam int NumLeds = 3;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] led_levels;
    logic       command_done;
    logic       overflow;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic tick;
    logic store;
    logic walk_start;
    logic issue;
    logic decode;
    logic finish;
    logic load_out;
    logic done;
    logic ovf;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic pairs_zero;
    logic rd_last;
  } stat_t;

endpackage

/* design/scled_dp.sv */
`timescale 1ns / 1ps

module scled_dp import scled_pkg::*; #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  cmd_t       cmd_i,
  output stat_t      stat_o,
  output out_t       out_data_o
);

  localparam int Pairs  = (BUFFER_BYTES + 1) / 2;
  localparam int PairAw = (Pairs > 1) ? $clog2(Pairs) : 1;
  localparam int WiW    = $clog2(BUFFER_BYTES + 1);
  localparam int PcW    = $clog2(Pairs + 1);
  localparam int CmpW   = WiW + PairAw + 1;
  localparam int BndW   = PcW + WiW + 1;

  // Frame buffer, one pair of bytes per word
  logic [15:0] mem [Pairs];

  logic [WiW-1:0]    wi_q, wi_d;
  logic [PcW-1:0]    pnz_q, pnz_d;
  logic              lo_zero_q, lo_zero_d;
  logic [PairAw-1:0] ptr_q;
  logic [15:0]       rdata_q;
  logic              hi_ok_q;
  logic [7:0]        reload_q [NumLeds];
  logic [7:0]        reload_d [NumLeds];
  logic [7:0]        count_q  [NumLeds];
  logic [7:0]        count_d  [NumLeds];
  logic [7:0]        cnt_dec  [NumLeds];
  logic [2:0]        led_q, led_d;
  out_t              out_q;

  logic [PairAw-1:0] wr_addr;
  logic              wr_hi;
  logic              byte_nz;
  logic              hi_ok;
  logic [7:0]        ch, dg, lvl, ch_off;
  logic [1:0]        chan;
  logic              ch_ok;

  assign wr_addr = PairAw'(wi_q >> 1);
  assign wr_hi   = wi_q[0];
  assign byte_nz = (rx_byte_i != 8'd0);
  // second byte of the pair only counts if it was written this frame
  assign hi_ok   = CmpW'({ptr_q, 1'b1}) < CmpW'(wi_q);

  // Buffer write and pair read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      if (wr_hi) begin
        mem[wr_addr][15:8] <= rx_byte_i;
      end else begin
        mem[wr_addr][7:0] <= rx_byte_i;
      end
    end
    if (cmd_i.issue) begin
      rdata_q <= mem[ptr_q];
      hi_ok_q <= hi_ok;
    end
  end

  // Fill index and running count of non-zero pairs
  always_comb begin
    wi_d      = wi_q;
    pnz_d     = pnz_q;
    lo_zero_d = lo_zero_q;
    if (cmd_i.finish) begin
      wi_d      = '0;
      pnz_d     = '0;
      lo_zero_d = 1'b1;
    end else if (cmd_i.store) begin
      wi_d = wi_q + 1'b1;
      if (!wr_hi) begin
        lo_zero_d = !byte_nz;
        if (byte_nz) pnz_d = pnz_q + 1'b1;
      end else if (byte_nz && lo_zero_q) begin
        pnz_d = pnz_q + 1'b1;
      end
    end
  end

  // Pair decode
  assign ch     = rdata_q[7:0];
  assign dg     = hi_ok_q ? rdata_q[15:8] : 8'd0;
  assign lvl    = dg - DigitBase;
  assign ch_ok  = (ch >= ChanFirst) && (ch <= ChanLast);
  assign ch_off = ch - ChanFirst;
  assign chan   = ch_off[1:0];

  for (genvar n = 0; n < NumLeds; n++) begin : g_dec
    assign cnt_dec[n] = count_q[n] - 8'd1;
  end

  // Blink counters and LED levels
  always_comb begin
    led_d    = led_q;
    reload_d = reload_q;
    count_d  = count_q;
    if (cmd_i.tick) begin
      for (int n = 0; n < NumLeds; n++) begin
        if (count_q[n] != 8'd0) begin
          count_d[n] = cnt_dec[n];
          if (cnt_dec[n] == 8'd1) begin
            led_d[n]   = ~led_q[n];
            count_d[n] = reload_q[n];
          end
        end
      end
    end
    if (cmd_i.decode && ch_ok) begin
      unique case (lvl)
        LvlSlow: begin
          reload_d[chan] = ReloadSlow;
          count_d[chan]  = ReloadSlow;
        end
        LvlMid: begin
          reload_d[chan] = ReloadMid;
          count_d[chan]  = ReloadMid;
        end
        LvlFast: begin
          reload_d[chan] = ReloadFast;
          count_d[chan]  = ReloadFast;
        end
        LvlHigh: begin
          led_d[chan]    = 1'b1;
          reload_d[chan] = 8'd0;
          count_d[chan]  = 8'd0;
        end
        LvlLow: begin
          led_d[chan]    = 1'b0;
          reload_d[chan] = 8'd0;
          count_d[chan]  = 8'd0;
        end
        default: begin
          reload_d[chan] = 8'd0;
          count_d[chan]  = 8'd0;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      pnz_q     <= '0;
      lo_zero_q <= 1'b1;
      ptr_q     <= '0;
      led_q     <= '0;
      for (int n = 0; n < NumLeds; n++) begin
        reload_q[n] <= 8'd0;
        count_q[n]  <= 8'd0;
      end
    end else begin
      wi_q      <= wi_d;
      pnz_q     <= pnz_d;
      lo_zero_q <= lo_zero_d;
      led_q     <= led_d;
      reload_q  <= reload_d;
      count_q   <= count_d;
      if (cmd_i.walk_start) begin
        ptr_q <= '0;
      end else if (cmd_i.issue) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.led_levels   <= led_d;
      out_q.command_done <= cmd_i.done;
      out_q.overflow     <= cmd_i.ovf;
    end
  end

  assign out_data_o        = out_q;
  assign stat_o.full       = (wi_q == WiW'(BUFFER_BYTES));
  assign stat_o.pairs_zero = (pnz_q == '0);
  assign stat_o.rd_last    = ((PcW'(ptr_q) + 1'b1) == pnz_q);

  // never store into a full buffer
  a_no_store_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> !stat_o.full)
    else $error("store into full buffer");

  // non-zero pairs never exceed pairs touched so far
  a_pnz_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    BndW'({pnz_q, 1'b0}) <= (BndW'(wi_q) + BndW'(1)))
    else $error("pair count exceeds fill");

  // a buffer walk only runs over a non-empty pair count
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (pnz_q != '0))
    else $error("walk with zero pairs");

endmodule

/* design/scled_ctrl.sv */
`timescale 1ns / 1ps

module scled_ctrl import scled_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  in_t   in_data_i,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  output cmd_t  cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWalk  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_frame_q, in_frame_d;
  logic       dec_q, dec_d;
  logic       out_valid_q, out_valid_d;
  logic       is_mark;
  logic       accept;
  cmd_t       cmd;

  assign is_mark    = (in_data_i.rx_byte == FrameMark);
  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    in_frame_d = in_frame_q;
    dec_d      = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd.load_out = 1'b1;
          if (in_data_i.op == OpTick) begin
            cmd.tick = 1'b1;
          end else if (!in_frame_q) begin
            if (is_mark) in_frame_d = 1'b1;
          end else if (!is_mark) begin
            if (stat_i.full) begin
              cmd.ovf = 1'b1;
            end else begin
              cmd.store = 1'b1;
            end
          end else begin
            in_frame_d = 1'b0;
            if (stat_i.pairs_zero) begin
              cmd.finish = 1'b1;
              cmd.done   = 1'b1;
            end else begin
              cmd.load_out   = 1'b0;
              cmd.walk_start = 1'b1;
              state_d        = StWalk;
            end
          end
        end
      end
      StWalk: begin
        // read one pair per cycle, decode the one read before
        cmd.issue  = 1'b1;
        cmd.decode = dec_q;
        dec_d      = 1'b1;
        if (stat_i.rd_last) state_d = StDrain;
      end
      StDrain: begin
        cmd.decode   = dec_q;
        cmd.finish   = 1'b1;
        cmd.done     = 1'b1;
        cmd.load_out = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = cmd.load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_frame_q  <= 1'b0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_frame_q  <= in_frame_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

  // the last read is followed by its decode and the frame finish
  a_last_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk && stat_i.rd_last) |=> (state_q == StDrain && dec_q))
    else $error("walk end without drain");

  // decode and tick never share a cycle
  a_dec_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.decode |-> !cmd.tick && (state_q != StIdle))
    else $error("decode outside walk");

endmodule

/* design/serial_command_led_blinker_top.sv */
`timescale 1ns / 1ps

// Serial command LED blinker.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
// received serial byte (op = byte) or timer tick (op = tick). Output channel
// (out_valid_o / out_stall_i / out_data_o): exactly one result per input,
// carrying the LED levels and the frame-done and overflow flags.
// Ticks and bytes that do not close a frame give their result in the
// cycle after acceptance, and a new input can be taken every cycle while
// results are taken. A closing '*' walks the frame buffer one byte pair per
// cycle through its single read port: the result follows a walk over the
// frame's P non-zero pairs (an empty frame is not walked), and the input is
// stalled over that walk.
// Reset clears the frame state, fill count, blink counters and LED levels;
// buffer contents are not cleared, the fill count masks stale bytes.
// When the receiver stalls, the result is held in the output register and
// the input stalls only once a second result would be needed.
module serial_command_led_blinker_top import scled_pkg::*; #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  scled_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  scled_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (in_data_i.rx_byte),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
